// ----- hw/rtl/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// Types and constants shared by the connection sequence table.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int LIMIT_W = 5;
  localparam int SEQ_W   = 32;
  localparam int IN_W    = 320;
  localparam int OUT_W   = 64;

  // Next sequence of a newly inserted direction, and the ack of an absent one
  localparam logic [SEQ_W-1:0] SEQ_INIT = 32'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic        is_ipv6;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [31:0] ports;     // {src_port, dst_port}
  } flow_key_t;

  typedef struct packed {
    flow_key_t        key;
    logic [SEQ_W-1:0] next_seq;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

endpackage

// ----- hw/rtl/connection_sequence_table_top.sv -----
// ----------------------------------------------------------------------------
// connection_sequence_table_top
// Per-direction TCP sequence counters kept in an insertion-ordered table.
// ----------------------------------------------------------------------------
// Each input transfer names one TCP direction and a segment length; the block
// returns that direction's next sequence (inserting it at 1 on a miss, evicting
// the oldest entries once table_limit entries are live), advances it by the
// length, and returns the reverse direction's next sequence as ack, or 1. The
// whole table sits in one synchronous memory, and the scan reads one live
// entry per cycle, oldest first, matching the item and its reverse in the same
// pass; the last entry read is then compared, the scan is left, and the commit
// state writes back and loads the result, waiting while the output register is
// still full. A new input transfer is taken only in the idle state, after the
// write-back of the last item. Entries are only read inside the live window, so
// the memory needs no clearing after reset. A finished result waits in an
// output register while the next item is taken in.
module connection_sequence_table_top #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [cst_pkg::LIMIT_W-1:0] cfg_wdata,   // table_limit
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // src_addr_hi[63:0], src_addr_lo[127:64], dst_addr_hi[191:128],
  // dst_addr_lo[255:192], src_port[271:256], dst_port[287:272],
  // segment_length[319:288]
  input  logic [cst_pkg::IN_W-1:0] s_axis_tdata,
  input  logic                     s_axis_tuser,   // is_ipv6
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [cst_pkg::OUT_W-1:0] m_axis_tdata   // seq_number[31:0], ack_number[63:32]
);
  import cst_pkg::*;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LW     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [CNT_W:0]  DEPTH_S  = (CNT_W + 1)'(DEPTH);
  localparam logic [LW-1:0]   DEPTH_LW = LW'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(a) + {1'b0, b};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[SLOT_W-1:0];
  endfunction

  // control state
  state_t             state;
  logic [LIMIT_W-1:0] table_limit;
  logic [CNT_W-1:0]   entry_count;
  logic [SLOT_W-1:0]  oldest_slot;
  logic [CNT_W-1:0]   idx;
  logic               pend;
  logic               fwd_hit;
  logic               rev_hit;

  // item payload
  flow_key_t          fwd_key;
  flow_key_t          rev_key;
  logic [SEQ_W-1:0]   seg_len;
  logic               self_rev;
  logic [CNT_W-1:0]   pend_idx;
  logic [SLOT_W-1:0]  pend_slot;
  logic [SLOT_W-1:0]  fwd_slot;
  logic [SEQ_W-1:0]   fwd_seq;
  logic [CNT_W-1:0]   rev_idx;
  logic [SEQ_W-1:0]   rev_seq;

  // table memory
  entry_t             mem [DEPTH];
  entry_t             rd_data;
  entry_t             mem_wdata;
  logic [SLOT_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  mem_waddr;
  logic               rd_en;
  logic               mem_we;

  flow_key_t          in_key;
  logic               in_fire;
  logic               out_free;
  logic               commit;
  logic [LW-1:0]      tl_ext;
  logic [LW-1:0]      lim_w;
  logic [CNT_W-1:0]   lim;
  logic               evict;
  logic [CNT_W-1:0]   n_evict;
  logic [SLOT_W-1:0]  new_slot;
  logic [SEQ_W-1:0]   seq_cur;
  logic [SEQ_W-1:0]   seq_new;
  logic [SEQ_W-1:0]   ack;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign commit        = (state == ST_COMMIT) && out_free;

  // IPv4 keys use only the low 32 bits of each address
  always_comb begin
    in_key.is_ipv6 = s_axis_tuser;
    in_key.src_hi  = s_axis_tuser ? s_axis_tdata[63:0] : 64'd0;
    in_key.src_lo  = s_axis_tuser ? s_axis_tdata[127:64] : {32'd0, s_axis_tdata[95:64]};
    in_key.dst_hi  = s_axis_tuser ? s_axis_tdata[191:128] : 64'd0;
    in_key.dst_lo  = s_axis_tuser ? s_axis_tdata[255:192] : {32'd0, s_axis_tdata[223:192]};
    in_key.ports   = {s_axis_tdata[271:256], s_axis_tdata[287:272]};
  end

  always_comb begin
    rev_key.is_ipv6 = fwd_key.is_ipv6;
    rev_key.src_hi  = fwd_key.dst_hi;
    rev_key.src_lo  = fwd_key.dst_lo;
    rev_key.dst_hi  = fwd_key.src_hi;
    rev_key.dst_lo  = fwd_key.src_lo;
    rev_key.ports   = {fwd_key.ports[15:0], fwd_key.ports[31:16]};
  end

  // scan reads one live entry per cycle, oldest first
  assign rd_en   = (state == ST_SCAN) && (idx != entry_count);
  assign rd_addr = wrap_add(oldest_slot, idx);

  // effective limit: zero acts as one, clipped to the depth
  always_comb begin
    tl_ext = LW'(table_limit);
    if (table_limit == '0) begin
      lim_w = LW'(1);
    end else if (tl_ext > DEPTH_LW) begin
      lim_w = DEPTH_LW;
    end else begin
      lim_w = tl_ext;
    end
    lim = lim_w[CNT_W-1:0];
  end

  always_comb begin
    evict    = !fwd_hit && (entry_count >= lim);
    n_evict  = evict ? (entry_count - lim + CNT_W'(1)) : '0;
    // new entry lands right after the live window, eviction or not
    new_slot = wrap_add(oldest_slot, entry_count);
    seq_cur  = fwd_hit ? fwd_seq : SEQ_INIT;
    seq_new  = seq_cur + seg_len;
    // reverse entry counts only if it survived eviction
    if (self_rev) begin
      ack = seq_new;
    end else if (rev_hit && (rev_idx >= n_evict)) begin
      ack = rev_seq;
    end else begin
      ack = SEQ_INIT;
    end
    mem_we             = commit;
    mem_waddr          = fwd_hit ? fwd_slot : new_slot;
    mem_wdata.key      = fwd_key;
    mem_wdata.next_seq = seq_new;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      table_limit   <= LIMIT_RESET;
      entry_count   <= '0;
      oldest_slot   <= '0;
      idx           <= '0;
      pend          <= 1'b0;
      fwd_hit       <= 1'b0;
      rev_hit       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        table_limit <= cfg_wdata;
      end
      pend <= rd_en;
      if (commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            idx     <= '0;
            fwd_hit <= 1'b0;
            rev_hit <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            idx <= idx + CNT_W'(1);
          end
          if (pend) begin
            if (rd_data.key == fwd_key) begin
              fwd_hit <= 1'b1;
            end
            if (rd_data.key == rev_key) begin
              rev_hit <= 1'b1;
            end
          end
          if (!rd_en && !pend) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            if (!fwd_hit) begin
              entry_count <= evict ? lim : entry_count + CNT_W'(1);
              if (evict) begin
                oldest_slot <= wrap_add(oldest_slot, n_evict);
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_key  <= in_key;
      seg_len  <= s_axis_tdata[319:288];
      self_rev <= (in_key.src_hi == in_key.dst_hi) && (in_key.src_lo == in_key.dst_lo)
                  && (in_key.ports[31:16] == in_key.ports[15:0]);
    end
    if (rd_en) begin
      pend_idx  <= idx;
      pend_slot <= rd_addr;
    end
    if (pend && (rd_data.key == fwd_key)) begin
      fwd_slot <= pend_slot;
      fwd_seq  <= rd_data.next_seq;
    end
    if (pend && (rd_data.key == rev_key)) begin
      rev_idx <= pend_idx;
      rev_seq <= rd_data.next_seq;
    end
    if (commit) begin
      m_axis_tdata <= {ack, seq_cur};
    end
  end

  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= DEPTH_C)
    else $error("entry count above table depth");

  a_read_in_window: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (idx < entry_count))
    else $error("scan read outside live window");

  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !pend)
    else $error("memory read pending while idle");

  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> (m_axis_tvalid && (entry_count != '0)))
    else $error("commit without result or with empty table");

  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    (commit && !fwd_hit) |=> (entry_count <= $past(lim)))
    else $error("insert left table over limit");

endmodule

// ----- bench/seq_ack_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seq_ack_checker
// Watches the segment and result streams, tracks the table and checks results.
// ----------------------------------------------------------------------------
// Keeps its own insertion-ordered copy of the per-direction counters. Each
// segment transfer is run through it to get the expected seq/ack pair. Each
// result transfer is compared field by field against the oldest pending pair.
module seq_ack_checker #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [cst_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [cst_pkg::IN_W-1:0]    s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [cst_pkg::OUT_W-1:0]   m_axis_tdata,
  output int                          mismatches,
  output int                          outstanding,
  output int                          results_seen,
  output int                          table_hits,
  output int                          evictions
);
  import cst_pkg::*;

  // ack in the upper half, seq in the lower half, as on m_axis_tdata
  typedef struct packed {
    logic [SEQ_W-1:0] ack;
    logic [SEQ_W-1:0] seq;
  } seq_ack_t;

  flow_key_t          key_mem [DEPTH];
  logic [SEQ_W-1:0]   next_mem [DEPTH];
  int                 live;
  int                 head;
  logic [LIMIT_W-1:0] limit_reg;
  seq_ack_t           pending_results [$];

  function automatic int find_flow(flow_key_t k);
    for (int i = 0; i < live; i++) begin
      if (key_mem[(head + i) % DEPTH] == k) return (head + i) % DEPTH;
    end
    return -1;
  endfunction

  function automatic int usable_limit();
    if (limit_reg == 0) return 1;
    if (limit_reg > DEPTH) return DEPTH;
    return int'(limit_reg);
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic advance_flow(input logic [IN_W-1:0] d, input logic v6,
                              output seq_ack_t res);
    flow_key_t        fwd;
    flow_key_t        rev;
    int               slot;
    int               rslot;
    int               cap;
    logic [SEQ_W-1:0] len;
    // IPv4 keys only use the low 32 bits of each address
    fwd.is_ipv6 = v6;
    fwd.src_hi  = v6 ? d[63:0]    : 64'd0;
    fwd.src_lo  = v6 ? d[127:64]  : {32'd0, d[95:64]};
    fwd.dst_hi  = v6 ? d[191:128] : 64'd0;
    fwd.dst_lo  = v6 ? d[255:192] : {32'd0, d[223:192]};
    fwd.ports   = {d[271:256], d[287:272]};
    len         = d[319:288];
    rev.is_ipv6 = v6;
    rev.src_hi  = fwd.dst_hi;
    rev.src_lo  = fwd.dst_lo;
    rev.dst_hi  = fwd.src_hi;
    rev.dst_lo  = fwd.src_lo;
    rev.ports   = {fwd.ports[15:0], fwd.ports[31:16]};

    slot = find_flow(fwd);
    if (slot < 0) begin
      cap = usable_limit();
      while (live >= cap) begin
        head = (head + 1) % DEPTH;
        live--;
        evictions++;
      end
      slot = (head + live) % DEPTH;
      key_mem[slot]  = fwd;
      next_mem[slot] = SEQ_INIT;
      live++;
    end else begin
      table_hits++;
    end
    res.seq        = next_mem[slot];
    next_mem[slot] = next_mem[slot] + len;
    // reverse lookup sees the counter just advanced
    rslot   = find_flow(rev);
    res.ack = (rslot < 0) ? SEQ_INIT : next_mem[rslot];
  endtask

  always @(posedge clk) begin : watch
    seq_ack_t got;
    seq_ack_t want;
    seq_ack_t fresh;
    if (rst) begin
      live      = 0;
      head      = 0;
      limit_reg = LIMIT_RESET;
      pending_results.delete();
    end else begin
      if (cfg_wen) limit_reg = cfg_wdata;
      // results first: a result never belongs to a segment taken on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        results_seen++;
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result with nothing pending: seq %08h ack %08h",
                                 got.seq, got.ack));
        end else begin
          want = pending_results.pop_front();
          if (got.seq !== want.seq)
            note_failure($sformatf("result %0d seq_number: expected %08h, got %08h",
                                   results_seen, want.seq, got.seq));
          if (got.ack !== want.ack)
            note_failure($sformatf("result %0d ack_number: expected %08h, got %08h",
                                   results_seen, want.ack, got.ack));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_flow(s_axis_tdata, s_axis_tuser, fresh);
        pending_results.push_back(fresh);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the connection sequence table.
// ----------------------------------------------------------------------------
// A directed run covers address masking, family, wraparound, self-directed
// flows and lowering the limit below the live count. Random phases then mix a
// small pool of flows in both directions with fresh ones, under limits from
// zero to above the table depth, with random gaps, a long output stall and a
// final stretch without gaps. Checking is done by seq_ack_checker.
module tb_top;
  import cst_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 25;
  localparam int PHASE_ITEMS    = 250;
  localparam int NUM_PHASES     = 8;
  localparam int POOL_SIZE      = 24;

  typedef struct {
    logic        v6;
    logic [63:0] a_hi;
    logic [63:0] a_lo;
    logic [63:0] b_hi;
    logic [63:0] b_lo;
    logic [15:0] pa;
    logic [15:0] pb;
  } flow_t;

  logic               clk;
  logic               rst           = 1'b1;
  logic               cfg_wen       = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata     = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;

  int mismatches;
  int outstanding;
  int results_seen;
  int table_hits;
  int evictions;
  int segments_sent;

  bit steady_run;   // no gaps on either side
  bit hold_req;     // ask the receiver for one long stall
  bit hold_taken;   // receiver has started the long stall
  int stall_left;

  flow_t pool [POOL_SIZE];
  int    phase_limit [NUM_PHASES] = '{16, 3, 0, 1, 31, 8, 17, 16};

  connection_sequence_table_top #(.DEPTH(16)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  seq_ack_checker #(.DEPTH(16)) u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .table_hits   (table_hits),
    .evictions    (evictions)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (!steady_run && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_length();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(1, 1500);
    endcase
  endfunction

  function automatic flow_t rand_flow();
    flow_t f;
    f.v6   = 1'($urandom_range(0, 1));
    f.a_hi = rand64();
    f.a_lo = rand64();
    f.b_hi = rand64();
    f.b_lo = rand64();
    f.pa   = 16'($urandom);
    f.pb   = 16'($urandom);
    // self-directed flow: forward and reverse key are the same
    if ($urandom_range(0, 7) == 0) begin
      f.b_hi = f.a_hi;
      f.b_lo = f.a_lo;
      f.pb   = f.pa;
    end
    return f;
  endfunction

  // Called just after a falling edge; returns just after a falling edge, once the segment has been accepted.
  task automatic send_seg(input logic v6, input logic [63:0] shi, slo, dhi, dlo,
                          input logic [15:0] sp, dp, input logic [31:0] len);
    int gap;
    if (!steady_run && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= v6;
    s_axis_tdata  <= {len, dp, sp, dlo, dhi, slo, shi};
    do @(posedge clk); while (!s_axis_tready);
    segments_sent++;
    @(negedge clk);
  endtask

  // IPv4 flows get fresh junk in the ignored address bits on every transfer
  task automatic send_flow(input flow_t f, input bit reverse, input logic [31:0] len);
    logic [63:0] ahi;
    logic [63:0] alo;
    logic [63:0] bhi;
    logic [63:0] blo;
    ahi = f.v6 ? f.a_hi : rand64();
    alo = f.v6 ? f.a_lo : {$urandom, f.a_lo[31:0]};
    bhi = f.v6 ? f.b_hi : rand64();
    blo = f.v6 ? f.b_lo : {$urandom, f.b_lo[31:0]};
    if (reverse) send_seg(f.v6, bhi, blo, ahi, alo, f.pb, f.pa, len);
    else         send_seg(f.v6, ahi, alo, bhi, blo, f.pa, f.pb, len);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin : stimulus
    logic [63:0] addr_a;
    logic [63:0] addr_b;
    int          span;
    flow_t       f;
    addr_a = 64'hDEAD_BEEF_0A00_0001;
    addr_b = 64'h1234_5678_0A00_0002;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, at the reset limit
    send_seg(1'b0, rand64(), addr_a, rand64(), addr_b, 16'd1000, 16'd80, 32'd100);
    send_seg(1'b0, rand64(), addr_b, rand64(), addr_a, 16'd80, 16'd1000, 32'd50);
    // junk in the upper address bits must still hit; length wraps the counter
    send_seg(1'b0, rand64(), {32'hFFFF_FFFF, addr_a[31:0]}, 64'd0, addr_b,
             16'd1000, 16'd80, 32'hFFFF_FFFF);
    send_seg(1'b0, 64'd0, addr_a, 64'd0, addr_b, 16'd1000, 16'd80, 32'd0);
    // same values as IPv6: different family, separate entry
    send_seg(1'b1, 64'd0, addr_a, 64'd0, addr_b, 16'd1000, 16'd80, 32'd9);
    send_seg(1'b1, '1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 32'd7);
    send_seg(1'b1, '1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 32'd0);
    send_seg(1'b1, '0, '0, '0, '0, 16'd0, 16'd0, 32'hFFFF_FFFF);
    send_seg(1'b0, '0, '0, '0, '0, 16'd0, 16'hFFFF, 32'd1);
    send_seg(1'b1, '1, '1, '0, '0, 16'h1234, 16'h4321, 32'd20);
    send_seg(1'b1, '0, '0, '1, '1, 16'h4321, 16'h1234, 32'd5);

    // limit dropped below the live count: old entries stay visible until an insert
    drain();
    set_limit(5'd2);
    send_seg(1'b0, 64'd0, addr_a, 64'd0, addr_b, 16'd1000, 16'd80, 32'd3);
    send_seg(1'b0, 64'd0, 64'h0C0A_0001, 64'd0, 64'h0C0A_0002, 16'd5, 16'd6, 32'd11);
    send_seg(1'b0, 64'd0, addr_a, 64'd0, addr_b, 16'd1000, 16'd80, 32'd3);

    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = rand_flow();
      // twin flow differing only in family
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        pool[i]    = pool[i-1];
        pool[i].v6 = ~pool[i-1].v6;
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_limit(LIMIT_W'(phase_limit[p]));
      steady_run = (p == NUM_PHASES - 1);
      span = $urandom_range(2, POOL_SIZE - 1);
      repeat ($urandom_range(0, 3)) pool[$urandom_range(0, POOL_SIZE - 1)] = rand_flow();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 100) hold_req = 1'b1;
        if (p == 2 && n == 125) drain();
        if ($urandom_range(0, 9) == 0) f = rand_flow();
        else                           f = pool[$urandom_range(0, span)];
        send_flow(f, 1'($urandom_range(0, 1)), rand_length());
      end
    end

    drain();
    $display("Covered %0d segment transfers and %0d results: %0d table hits, %0d evictions",
             segments_sent, results_seen, table_hits, evictions);
    $display("Limits 16, 2, 3, 0, 1, 31, 8, 17 with IPv4/IPv6 flows, stalls and wraparound");
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
